### hdl/byte_ring_queue_with_peek_core_defines.svh
// Assertion macros used by the queue controller RTL.
`ifndef BYTE_RING_QUEUE_WITH_PEEK_CORE_DEFINES_SVH
`define BYTE_RING_QUEUE_WITH_PEEK_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define BRQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("brq assertion failed");

`define BRQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("brq assertion failed");

`else

`define BRQ_ASSERT(lbl, clk, rst_n, prop)

`define BRQ_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### hdl/brq_pkg.sv
`default_nettype none
package brq_pkg;

  localparam logic [2:0] KIND_INSERT  = 3'd0;
  localparam logic [2:0] KIND_REMOVE  = 3'd1;
  localparam logic [2:0] KIND_INSPECT = 3'd2;
  localparam logic [2:0] KIND_SYNC    = 3'd3;
  localparam logic [2:0] KIND_FLUSH   = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_in;
  } brq_in_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  data_out;
    logic [6:0]  free_count;
    logic [6:0]  used_count;
    logic        empty_res;
    logic        peek_empty;
    logic [15:0] overflow_total;
  } brq_out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } brq_cmd_t;

endpackage
`default_nettype wire

### hdl/brq_ctrl.sv
`default_nettype none
`include "byte_ring_queue_with_peek_core_defines.svh"
module brq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output brq_pkg::brq_cmd_t      cmd
);
  import brq_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state_r == ST_EXEC);
  assign cmd.load    = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (cmd.load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BRQ_ASSERT(a_capture_to_exec, clk, rst_n, cmd.capture |=> (state_r == ST_EXEC))
  `BRQ_ASSERT(a_exec_to_finish, clk, rst_n, cmd.exec |=> (state_r == ST_FINISH))
  `BRQ_ASSERT(a_load_sets_valid, clk, rst_n, cmd.load |=> (out_valid_r && in_ready))
  `BRQ_ASSERT(a_no_load_when_full, clk, rst_n, (out_valid_r && !out_ready) |-> !cmd.load)

endmodule
`default_nettype wire

### hdl/brq_dpath.sv
`default_nettype none
module brq_dpath #(
  parameter int DEPTH = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire brq_pkg::brq_in_t  in_data,
  input  wire brq_pkg::brq_cmd_t cmd,
  output brq_pkg::brq_out_t      out_data
);
  import brq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = PW + 1;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_r;

  brq_in_t       op_r;
  brq_out_t      out_r;
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [PW-1:0] pptr_r, pptr_nxt;
  logic [15:0]   ovf_r, ovf_nxt;
  logic          ok_r, ok_nxt;
  logic          hit_r, hit_nxt;

  logic [CW-1:0] used;
  logic          full;
  logic          w_eq_r;
  logic          w_eq_p;
  logic          mem_we;
  logic          mem_re;
  logic [PW-1:0] rd_addr;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign used   = {1'b0, wptr_r} - {1'b0, rptr_r}
                + ((wptr_r < rptr_r) ? CW'(DEPTH) : '0);
  assign full   = (used == CW'(DEPTH - 1));
  assign w_eq_r = (wptr_r == rptr_r);
  assign w_eq_p = (wptr_r == pptr_r);

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    pptr_nxt = pptr_r;
    ovf_nxt  = ovf_r;
    ok_nxt   = 1'b0;
    hit_nxt  = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    rd_addr  = rptr_r;
    case (op_r.kind)
      KIND_INSERT: begin
        if (full) begin
          if (ovf_r != 16'hFFFF) ovf_nxt = ovf_r + 16'd1;
        end else begin
          mem_we   = 1'b1;
          wptr_nxt = ptr_inc(wptr_r);
          ok_nxt   = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (!w_eq_r) begin
          mem_re   = 1'b1;
          rptr_nxt = ptr_inc(rptr_r);
          ok_nxt   = 1'b1;
          hit_nxt  = 1'b1;
        end
      end
      KIND_INSPECT: begin
        rd_addr = pptr_r;
        if (!w_eq_p) begin
          mem_re   = 1'b1;
          pptr_nxt = ptr_inc(pptr_r);
          ok_nxt   = 1'b1;
          hit_nxt  = 1'b1;
        end
      end
      KIND_SYNC: begin
        rptr_nxt = pptr_r;
        ok_nxt   = 1'b1;
      end
      KIND_FLUSH: begin
        wptr_nxt = '0;
        rptr_nxt = '0;
        pptr_nxt = '0;
        ok_nxt   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) mem[wptr_r] <= op_r.data_in;
    if (cmd.exec && mem_re) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      pptr_r <= '0;
      ovf_r  <= '0;
    end else if (cmd.exec) begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      pptr_r <= pptr_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) op_r <= in_data;
    if (cmd.exec) begin
      ok_r  <= ok_nxt;
      hit_r <= hit_nxt;
    end
    if (cmd.load) begin
      out_r.ok             <= ok_r;
      out_r.data_out       <= hit_r ? rdata_r : 8'd0;
      out_r.free_count     <= 7'(CW'(DEPTH - 1) - used);
      out_r.used_count     <= 7'(used);
      out_r.empty_res      <= w_eq_r;
      out_r.peek_empty     <= w_eq_p;
      out_r.overflow_total <= ovf_r;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

### hdl/byte_ring_queue_with_peek_core.sv
// Channel   Dir  Handshake            Payload
// in_       in   in_valid/in_ready    in_data   (brq_in_t: kind, data_in)
// out_      out  out_valid/out_ready  out_data  (brq_out_t: status and byte)
//
// An operation runs as operand capture, registered ring memory access with
// pointer update, and result load, in that order.
// The next operation is taken while a result waits in the output register.
// A stalled output holds the result load until the output register frees.
// Synchronous reset clears pointers and overflow count; stored bytes are kept.
`default_nettype none
module byte_ring_queue_with_peek_core #(
  parameter int DEPTH = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire brq_pkg::brq_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output brq_pkg::brq_out_t      out_data
);
  import brq_pkg::*;

  brq_cmd_t cmd;

  brq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  brq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

### tb/sv/tb_byte_ring_queue_with_peek_core.sv
`timescale 1ns / 1ps
module tb_byte_ring_queue_with_peek_core;
  import brq_pkg::*;

  localparam int DEPTH      = 128;
  localparam int MAX_GAP    = 12;
  localparam int RANDOM_OPS = 500;
  localparam int OVF_MAX    = 65535;
  localparam int MAX_PRINTS = 50;

  localparam logic [2:0] KIND_RSVD5 = 3'd5;
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_PEEK, MODE_MIXED} traffic_mode_e;

  typedef struct {
    brq_in_t  op;
    int       reps;
    bit       typed;
    brq_out_t want;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  brq_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  brq_out_t out_data;

  // ring shadow
  logic [7:0]  ring_mem [DEPTH];
  bit          slot_written [DEPTH];
  int          wr_slot;
  int          rd_slot;
  int          pk_slot;
  int unsigned overflow_cnt;
  brq_out_t    pending_status [$];

  bit tx_idle_en;
  bit rx_idle_en;
  int mismatches;
  int ops_sent;
  int results_seen;

  byte_ring_queue_with_peek_core #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("byte_ring_queue_with_peek_core: mismatch");
    $finish;
  end

  function automatic int ring_fill();
    return (wr_slot + DEPTH - rd_slot) % DEPTH;
  endfunction

  function automatic brq_out_t ring_apply(brq_in_t op);
    brq_out_t r;
    r = '0;
    case (op.kind)
      KIND_INSERT: begin
        if (ring_fill() == DEPTH - 1) begin
          if (overflow_cnt < OVF_MAX) overflow_cnt++;
        end else begin
          ring_mem[wr_slot] = op.data_in;
          slot_written[wr_slot] = 1'b1;
          wr_slot = (wr_slot + 1) % DEPTH;
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (wr_slot != rd_slot) begin
          r.data_out = ring_mem[rd_slot];
          rd_slot = (rd_slot + 1) % DEPTH;
          r.ok = 1'b1;
        end
      end
      KIND_INSPECT: begin
        if (wr_slot != pk_slot) begin
          r.data_out = ring_mem[pk_slot];
          pk_slot = (pk_slot + 1) % DEPTH;
          r.ok = 1'b1;
        end
      end
      KIND_SYNC: begin
        rd_slot = pk_slot;
        r.ok = 1'b1;
      end
      KIND_FLUSH: begin
        wr_slot = 0;
        rd_slot = 0;
        pk_slot = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.free_count     = 7'(DEPTH - 1 - ring_fill());
    r.used_count     = 7'(ring_fill());
    r.empty_res      = (wr_slot == rd_slot);
    r.peek_empty     = (wr_slot == pk_slot);
    r.overflow_total = 16'(overflow_cnt);
    return r;
  endfunction

  function automatic brq_out_t status(bit ok, int used, bit pk_empty, int ovf);
    brq_out_t s;
    s = '0;
    s.ok             = ok;
    s.free_count     = 7'(DEPTH - 1 - used);
    s.used_count     = 7'(used);
    s.empty_res      = (used == 0);
    s.peek_empty     = pk_empty;
    s.overflow_total = 16'(ovf);
    return s;
  endfunction

  function automatic plan_row_t step(logic [2:0] kind, logic [7:0] data, int reps,
                                     bit typed, brq_out_t want);
    plan_row_t row;
    row.op.kind    = kind;
    row.op.data_in = data;
    row.reps       = reps;
    row.typed      = typed;
    row.want       = want;
    return row;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, what);
  endtask

  task automatic cmp_field(input string name, input logic [15:0] got,
                           input logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s: got %0h want %0h",
                              results_seen, name, got, want));
  endtask

  task automatic check_result(input brq_out_t got);
    brq_out_t want;
    results_seen++;
    if (pending_status.size() == 0) begin
      flag_mismatch($sformatf("result %0d with no operation outstanding", results_seen));
      return;
    end
    want = pending_status.pop_front();
    cmp_field("ok", 16'(got.ok), 16'(want.ok));
    cmp_field("data_out", 16'(got.data_out), 16'(want.data_out));
    cmp_field("free_count", 16'(got.free_count), 16'(want.free_count));
    cmp_field("used_count", 16'(got.used_count), 16'(want.used_count));
    cmp_field("empty_res", 16'(got.empty_res), 16'(want.empty_res));
    cmp_field("peek_empty", 16'(got.peek_empty), 16'(want.peek_empty));
    cmp_field("overflow_total", got.overflow_total, want.overflow_total);
  endtask

  task automatic sink_results();
    int stall;
    forever begin
      stall = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_result(out_data);
    end
  endtask

  // valid stays high across back-to-back transfers
  task automatic send_op(input brq_in_t op, input bit typed, input brq_out_t want);
    int gap;
    brq_out_t predicted;
    gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= op;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = ring_apply(op);
    pending_status.push_back(typed ? want : predicted);
    ops_sent++;
  endtask

  initial begin
    plan_row_t     plan [$];
    brq_in_t       op;
    traffic_mode_e mode;
    int            mode_left;
    int            useful;
    int            roll;
    int            w;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    wr_slot      = 0;
    rd_slot      = 0;
    pk_slot      = 0;
    overflow_cnt = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    mismatches   = 0;
    ops_sent     = 0;
    results_seen = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    fork
      sink_results();
    join_none

    plan.push_back(step(KIND_REMOVE,  8'h00, 1, 1'b1, status(1'b0, 0, 1'b1, 0)));
    plan.push_back(step(KIND_INSPECT, 8'hFF, 1, 1'b1, status(1'b0, 0, 1'b1, 0)));
    plan.push_back(step(KIND_SYNC,    8'h00, 1, 1'b1, status(1'b1, 0, 1'b1, 0)));
    plan.push_back(step(KIND_FLUSH,   8'hFF, 1, 1'b1, status(1'b1, 0, 1'b1, 0)));
    plan.push_back(step(KIND_RSVD5,   8'h00, 1, 1'b1, status(1'b0, 0, 1'b1, 0)));
    plan.push_back(step(KIND_RSVD6,   8'hFF, 1, 1'b1, status(1'b0, 0, 1'b1, 0)));
    plan.push_back(step(KIND_RSVD7,   8'h00, 1, 1'b1, status(1'b0, 0, 1'b1, 0)));
    plan.push_back(step(KIND_INSERT,  8'h00, 1, 1'b0, '0));
    plan.push_back(step(KIND_INSERT,  8'hFF, 1, 1'b0, '0));
    plan.push_back(step(KIND_INSERT,  8'h5A, 1, 1'b0, '0));
    plan.push_back(step(KIND_INSPECT, 8'h00, 1, 1'b0, '0));
    plan.push_back(step(KIND_INSPECT, 8'h00, 1, 1'b0, '0));
    plan.push_back(step(KIND_REMOVE,  8'h00, 1, 1'b0, '0));
    // read jumps forward to peek
    plan.push_back(step(KIND_SYNC,    8'h00, 1, 1'b0, '0));
    plan.push_back(step(KIND_REMOVE,  8'h00, 1, 1'b0, '0));
    plan.push_back(step(KIND_REMOVE,  8'h00, 1, 1'b0, '0));
    plan.push_back(step(KIND_FLUSH,   8'h00, 1, 1'b1, status(1'b1, 0, 1'b1, 0)));
    plan.push_back(step(KIND_INSERT,  8'h00, DEPTH - 1, 1'b0, '0));
    plan.push_back(step(KIND_INSERT,  8'hFF, 1, 1'b1, status(1'b0, DEPTH - 1, 1'b0, 1)));
    plan.push_back(step(KIND_INSERT,  8'h00, 1, 1'b1, status(1'b0, DEPTH - 1, 1'b0, 2)));
    plan.push_back(step(KIND_INSPECT, 8'h00, DEPTH - 1, 1'b0, '0));
    plan.push_back(step(KIND_INSPECT, 8'h00, 1, 1'b1, status(1'b0, DEPTH - 1, 1'b1, 2)));
    plan.push_back(step(KIND_REMOVE,  8'h00, 3, 1'b0, '0));
    plan.push_back(step(KIND_INSERT,  8'h00, 3, 1'b0, '0));
    plan.push_back(step(KIND_SYNC,    8'h00, 1, 1'b0, '0));
    plan.push_back(step(KIND_REMOVE,  8'h00, 3, 1'b0, '0));
    plan.push_back(step(KIND_FLUSH,   8'h00, 1, 1'b1, status(1'b1, 0, 1'b1, 2)));
    plan.push_back(step(KIND_INSERT,  8'h00, 5, 1'b0, '0));
    plan.push_back(step(KIND_REMOVE,  8'h00, 5, 1'b0, '0));
    // read falls back to a lagging peek
    plan.push_back(step(KIND_SYNC,    8'h00, 1, 1'b0, '0));
    plan.push_back(step(KIND_REMOVE,  8'h00, 1, 1'b0, '0));

    foreach (plan[i]) begin
      for (int n = 0; n < plan[i].reps; n++) begin
        op = plan[i].op;
        if (plan[i].reps > 1) op.data_in = 8'($urandom);
        send_op(op, plan[i].typed, plan[i].want);
      end
    end

    mode      = MODE_MIXED;
    mode_left = 0;
    useful    = 0;
    while (useful < RANDOM_OPS) begin
      if (mode_left == 0) begin
        mode       = traffic_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 220);
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      mode_left--;
      op.data_in = 8'($urandom);
      roll = $urandom_range(0, 199);
      if (roll < 5) begin
        op.kind = 3'($urandom_range(KIND_RSVD5, KIND_RSVD7));
      end else if (roll < 8 && mode != MODE_FILL) begin
        op.kind = KIND_FLUSH;
      end else begin
        roll = $urandom_range(0, 99);
        case (mode)
          MODE_FILL: begin
            op.kind = roll < 85 ? KIND_INSERT : roll < 90 ? KIND_REMOVE :
                      roll < 97 ? KIND_INSPECT : KIND_SYNC;
          end
          MODE_DRAIN: begin
            op.kind = roll < 60 ? KIND_REMOVE : roll < 75 ? KIND_INSERT :
                      roll < 90 ? KIND_INSPECT : KIND_SYNC;
          end
          MODE_PEEK: begin
            op.kind = roll < 55 ? KIND_INSPECT : roll < 75 ? KIND_SYNC :
                      roll < 95 ? KIND_INSERT : KIND_REMOVE;
          end
          default: begin
            op.kind = roll < 30 ? KIND_INSERT : roll < 55 ? KIND_REMOVE :
                      roll < 80 ? KIND_INSPECT : KIND_SYNC;
          end
        endcase
      end
      // never read a slot that holds no data yet
      if (op.kind == KIND_REMOVE && rd_slot != wr_slot && !slot_written[rd_slot])
        op.kind = KIND_INSERT;
      if (op.kind == KIND_INSPECT && pk_slot != wr_slot && !slot_written[pk_slot])
        op.kind = KIND_INSERT;
      if (op.kind <= KIND_FLUSH) useful++;
      send_op(op, 1'b0, '0);
    end
    in_valid <= 1'b0;

    w = 0;
    while (pending_status.size() > 0 && w < 5000) begin
      @(posedge clk);
      w++;
    end
    repeat (20) @(posedge clk);
    if (pending_status.size() > 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_status.size()));

    $display("%0d operations in, %0d results checked: directed rows, random traffic, %s",
             ops_sent, results_seen, "full-ring refusals");
    $display("overflow count reached %0d, %0d mismatches", overflow_cnt, mismatches);
    if (mismatches == 0) begin
      $display("byte_ring_queue_with_peek_core: match");
    end else begin
      $display("byte_ring_queue_with_peek_core: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/brq_pkg.sv
hdl/brq_ctrl.sv
hdl/brq_dpath.sv
hdl/byte_ring_queue_with_peek_core.sv
tb/sv/tb_byte_ring_queue_with_peek_core.sv
